// File: design/aec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

    // Configuration and timer widths.
    localparam int CFG_W       = 20;
    localparam int HZ_W        = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int TIMER_W     = CFG_W + 1;
    localparam logic [TIMER_W-1:0] TIMER_CAP = TIMER_W'(1 << CFG_W);

    // Tone sweep step period default.
    localparam int TONE_STEP_MS_DEF = 1;

    // Cues per tick and queue sizing.
    localparam int MAX_CUES    = 6;
    localparam int CUE_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Register reset values.
    localparam logic [CFG_W-1:0] WARN_TO_SPEAK_RST  = 20'd8000;
    localparam logic [CFG_W-1:0] SPEAK_TO_SIREN_RST = 20'd8000;
    localparam logic [CFG_W-1:0] SIREN_TO_DEFEND_RST = 20'd10000;
    localparam logic [CFG_W-1:0] GUARD_BLINK_RST    = 20'd2000;
    localparam logic [CFG_W-1:0] WARN_BLINK_RST     = 20'd1000;
    localparam logic [CFG_W-1:0] SIREN_TOGGLE_RST   = 20'd3000;
    localparam logic [HZ_W-1:0]  TONE_LOW_RST       = 12'd200;
    localparam logic [HZ_W-1:0]  TONE_HIGH_RST      = 12'd1000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN_TO_SPEAK   = 3'd0,
        REG_SPEAK_TO_SIREN  = 3'd1,
        REG_SIREN_TO_DEFEND = 3'd2,
        REG_GUARD_BLINK     = 3'd3,
        REG_WARN_BLINK      = 3'd4,
        REG_SIREN_TOGGLE    = 3'd5,
        REG_TONE_LOW        = 3'd6,
        REG_TONE_HIGH       = 3'd7
    } cfg_reg_t;

    // Alarm levels.
    typedef enum logic [2:0] {
        LVL_DISARMED = 3'd0,
        LVL_DEFEND   = 3'd1,
        LVL_SIREN    = 3'd2,
        LVL_SPEAK    = 3'd3,
        LVL_WARN     = 3'd4,
        LVL_GUARD    = 3'd5
    } level_t;

    // Sound cues.
    typedef enum logic [2:0] {
        CUE_NONE   = 3'd0,
        CUE_SHORT  = 3'd1,
        CUE_DOUBLE = 3'd2,
        CUE_LONG   = 3'd3,
        CUE_LONGER = 3'd4
    } cue_t;

    // End-of-tick output levels shared by every result of a tick.
    typedef struct packed {
        logic [2:0]      level;
        logic            led;
        logic            buzzer;
        logic            siren;
        logic            tone_on;
        logic [HZ_W-1:0] tone_hz;
    } status_t;

    // One classified tick as handed from the front to the back.
    typedef struct packed {
        status_t                       status;
        logic [CUE_CNT_W-1:0]          cue_count;
        logic [MAX_CUES-1:0][2:0]      cues;
    } tick_rec_t;

    // Saturating millisecond timer step, with clear-before-increment.
    function automatic logic [TIMER_W-1:0] timer_next(input logic clr,
                                                      input logic [TIMER_W-1:0] t);
        logic [TIMER_W-1:0] base;
        base = clr ? '0 : t;
        return (base == TIMER_CAP) ? base : base + TIMER_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: design/aec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module aec_front #(
    parameter int TONE_STEP_MS = aec_pkg::TONE_STEP_MS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           take,
    input  wire logic [4:0]                     switches,
    input  wire logic                           cfg_write,
    input  wire logic [aec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aec_pkg::CFG_W-1:0]      cfg_data,
    output aec_pkg::tick_rec_t                  rec
);

    localparam int STEP_W = $clog2(TONE_STEP_MS + 1);
    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(TONE_STEP_MS);

    // Configuration registers.
    logic [aec_pkg::CFG_W-1:0] warn_to_speak_reg, speak_to_siren_reg, siren_to_defend_reg;
    logic [aec_pkg::CFG_W-1:0] guard_blink_reg, warn_blink_reg, siren_toggle_reg;
    logic [aec_pkg::HZ_W-1:0]  tone_low_reg, tone_high_reg;

    // Controller state.
    aec_pkg::level_t               level_reg, level_next;
    logic                          rb_reg, rb_next;
    logic [aec_pkg::TIMER_W-1:0]   level_t_reg, guard_t_reg, warn_t_reg, siren_t_reg;
    logic [STEP_W-1:0]             tone_t_reg, tone_t_next, tone_base;
    logic                          led_reg, led_next;
    logic                          buzz_reg, buzz_next;
    logic                          siren_reg, siren_next;
    logic                          tone_en_reg, tone_en_next;
    logic [aec_pkg::HZ_W-1:0]      freq_reg, freq_next;
    logic                          guard_clr, warn_clr, siren_clr, tone_clr;

    logic armed, gates, lockdown, panic, rst_btn;
    logic guard_fire, warn_fire, siren_fire, tone_fire;
    logic warn_due, speak_due, defend_due;

    logic [aec_pkg::MAX_CUES-1:0][2:0] cues_v;
    logic [aec_pkg::CUE_CNT_W-1:0]     ncue;

    assign armed    = switches[0];
    assign gates    = switches[1];
    assign lockdown = switches[2];
    assign panic    = switches[3];
    assign rst_btn  = switches[4];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_to_speak_reg   <= aec_pkg::WARN_TO_SPEAK_RST;
            speak_to_siren_reg  <= aec_pkg::SPEAK_TO_SIREN_RST;
            siren_to_defend_reg <= aec_pkg::SIREN_TO_DEFEND_RST;
            guard_blink_reg     <= aec_pkg::GUARD_BLINK_RST;
            warn_blink_reg      <= aec_pkg::WARN_BLINK_RST;
            siren_toggle_reg    <= aec_pkg::SIREN_TOGGLE_RST;
            tone_low_reg        <= aec_pkg::TONE_LOW_RST;
            tone_high_reg       <= aec_pkg::TONE_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aec_pkg::REG_WARN_TO_SPEAK:   warn_to_speak_reg   <= cfg_data;
                aec_pkg::REG_SPEAK_TO_SIREN:  speak_to_siren_reg  <= cfg_data;
                aec_pkg::REG_SIREN_TO_DEFEND: siren_to_defend_reg <= cfg_data;
                aec_pkg::REG_GUARD_BLINK:     guard_blink_reg     <= cfg_data;
                aec_pkg::REG_WARN_BLINK:      warn_blink_reg      <= cfg_data;
                aec_pkg::REG_SIREN_TOGGLE:    siren_toggle_reg    <= cfg_data;
                aec_pkg::REG_TONE_LOW:        tone_low_reg        <= cfg_data[aec_pkg::HZ_W-1:0];
                aec_pkg::REG_TONE_HIGH:       tone_high_reg       <= cfg_data[aec_pkg::HZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Timer expiry compares.
    assign guard_fire = guard_t_reg >= {1'b0, guard_blink_reg};
    assign warn_fire  = warn_t_reg  >= {1'b0, warn_blink_reg};
    assign siren_fire = siren_t_reg >= {1'b0, siren_toggle_reg};
    assign tone_fire  = tone_t_reg  >= STEP_CAP;
    assign warn_due   = level_t_reg >= {1'b0, warn_to_speak_reg};
    assign speak_due  = level_t_reg >= {1'b0, speak_to_siren_reg};
    assign defend_due = level_t_reg >= {1'b0, siren_to_defend_reg};

    // Next level, retrigger latch and the ordered cue list.
    always_comb
    begin
        level_next = level_reg;
        rb_next    = rb_reg;
        cues_v     = '0;
        ncue       = '0;
        unique case (level_reg)
            aec_pkg::LVL_DISARMED:
            begin
                if (armed)
                begin
                    level_next = aec_pkg::LVL_GUARD;
                    cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                end
            end
            aec_pkg::LVL_GUARD:
            begin
                if (armed)
                begin
                    if (gates)
                    begin
                        if (!rb_reg)
                        begin
                            if (lockdown)
                            begin
                                level_next = aec_pkg::LVL_SIREN;
                                cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                                cues_v[ncue] = aec_pkg::CUE_LONG;   ncue = ncue + 3'd1;
                            end
                            else
                            begin
                                level_next = aec_pkg::LVL_WARN;
                                cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                            end
                        end
                    end
                    else
                    begin
                        rb_next = 1'b0;
                    end
                end
                else
                begin
                    level_next = aec_pkg::LVL_DISARMED;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
                if (panic)
                begin
                    level_next = aec_pkg::LVL_SIREN;
                    cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                    cues_v[ncue] = aec_pkg::CUE_LONG;   ncue = ncue + 3'd1;
                end
            end
            aec_pkg::LVL_WARN, aec_pkg::LVL_SPEAK:
            begin
                // The warn beep is reported ahead of any transition cue.
                if (level_reg == aec_pkg::LVL_WARN && warn_fire)
                begin
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
                if (armed)
                begin
                    if (gates)
                    begin
                        if (level_reg == aec_pkg::LVL_WARN && warn_due)
                        begin
                            level_next = aec_pkg::LVL_SPEAK;
                            cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                        end
                        else if (level_reg == aec_pkg::LVL_SPEAK && speak_due)
                        begin
                            level_next = aec_pkg::LVL_SIREN;
                            cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                            cues_v[ncue] = aec_pkg::CUE_LONG;   ncue = ncue + 3'd1;
                        end
                    end
                    else
                    begin
                        level_next = aec_pkg::LVL_GUARD;
                        cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                    end
                end
                else
                begin
                    level_next = aec_pkg::LVL_DISARMED;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
                if (panic)
                begin
                    level_next = aec_pkg::LVL_SIREN;
                    cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                    cues_v[ncue] = aec_pkg::CUE_LONG;   ncue = ncue + 3'd1;
                end
                if (rst_btn)
                begin
                    rb_next    = 1'b1;
                    level_next = aec_pkg::LVL_GUARD;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
            end
            aec_pkg::LVL_SIREN:
            begin
                if (armed)
                begin
                    if (defend_due)
                    begin
                        level_next = aec_pkg::LVL_DEFEND;
                        cues_v[ncue] = aec_pkg::CUE_DOUBLE; ncue = ncue + 3'd1;
                        cues_v[ncue] = aec_pkg::CUE_LONGER; ncue = ncue + 3'd1;
                    end
                end
                else
                begin
                    level_next = aec_pkg::LVL_DISARMED;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
                if (rst_btn)
                begin
                    rb_next    = 1'b1;
                    level_next = aec_pkg::LVL_GUARD;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
            end
            aec_pkg::LVL_DEFEND:
            begin
                if (!armed)
                begin
                    level_next = aec_pkg::LVL_DISARMED;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
                if (rst_btn)
                begin
                    rb_next    = 1'b1;
                    level_next = aec_pkg::LVL_GUARD;
                    cues_v[ncue] = aec_pkg::CUE_SHORT; ncue = ncue + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Blink, tone sweep and siren actions, then the clear on a level change.
    always_comb
    begin
        led_next     = led_reg;
        buzz_next    = buzz_reg;
        siren_next   = siren_reg;
        tone_en_next = tone_en_reg;
        freq_next    = freq_reg;
        guard_clr    = 1'b0;
        warn_clr     = 1'b0;
        siren_clr    = 1'b0;
        tone_clr     = 1'b0;
        unique case (level_reg)
            aec_pkg::LVL_GUARD:
            begin
                if (guard_fire)
                begin
                    led_next  = !led_reg;
                    guard_clr = 1'b1;
                end
            end
            aec_pkg::LVL_WARN:
            begin
                if (warn_fire)
                begin
                    led_next  = 1'b0;
                    buzz_next = 1'b0;
                    warn_clr  = 1'b1;
                end
            end
            aec_pkg::LVL_SPEAK, aec_pkg::LVL_SIREN, aec_pkg::LVL_DEFEND:
            begin
                if (tone_fire)
                begin
                    freq_next    = (freq_reg >= tone_high_reg) ? tone_low_reg
                                                               : freq_reg + 12'd1;
                    tone_en_next = 1'b1;
                    tone_clr     = 1'b1;
                end
                if (level_reg != aec_pkg::LVL_SPEAK && siren_fire)
                begin
                    siren_next = !siren_reg;
                    buzz_next  = !buzz_reg;
                    siren_clr  = 1'b1;
                end
            end
            default: ;
        endcase
        if (level_next != level_reg)
        begin
            led_next     = 1'b0;
            buzz_next    = 1'b0;
            siren_next   = 1'b0;
            tone_en_next = 1'b0;
            freq_next    = tone_low_reg;
        end
    end

    // Tone step timer saturates at its own period.
    always_comb
    begin
        tone_base   = tone_clr ? '0 : tone_t_reg;
        tone_t_next = (tone_base >= STEP_CAP) ? STEP_CAP : tone_base + STEP_W'(1);
    end

    // State update on each accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= aec_pkg::LVL_DISARMED;
            rb_reg      <= 1'b0;
            level_t_reg <= '0;
            guard_t_reg <= '0;
            warn_t_reg  <= '0;
            siren_t_reg <= '0;
            tone_t_reg  <= '0;
            led_reg     <= 1'b0;
            buzz_reg    <= 1'b0;
            siren_reg   <= 1'b0;
            tone_en_reg <= 1'b0;
            freq_reg    <= aec_pkg::TONE_LOW_RST;
        end
        else if (take)
        begin
            level_reg   <= level_next;
            rb_reg      <= rb_next;
            level_t_reg <= aec_pkg::timer_next(level_next != level_reg, level_t_reg);
            guard_t_reg <= aec_pkg::timer_next(guard_clr, guard_t_reg);
            warn_t_reg  <= aec_pkg::timer_next(warn_clr, warn_t_reg);
            siren_t_reg <= aec_pkg::timer_next(siren_clr, siren_t_reg);
            tone_t_reg  <= tone_t_next;
            led_reg     <= led_next;
            buzz_reg    <= buzz_next;
            siren_reg   <= siren_next;
            tone_en_reg <= tone_en_next;
            freq_reg    <= freq_next;
        end
    end

    // Record of the tick for the result side.
    always_comb
    begin
        rec.status.level   = level_next;
        rec.status.led     = led_next;
        rec.status.buzzer  = buzz_next;
        rec.status.siren   = siren_next;
        rec.status.tone_on = tone_en_next;
        rec.status.tone_hz = freq_next;
        rec.cue_count      = ncue;
        rec.cues           = cues_v;
    end

endmodule

`default_nettype wire

// File: design/aec_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module aec_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire aec_pkg::tick_rec_t wr_rec,
    input  wire logic               pop,
    output aec_pkg::tick_rec_t      rd_rec,
    output logic                    full,
    output logic                    empty
);

    aec_pkg::tick_rec_t                 mem [aec_pkg::QUEUE_DEPTH];
    logic [aec_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [aec_pkg::QUEUE_CNT_W-1:0]    count_reg;

    assign full   = count_reg == aec_pkg::QUEUE_CNT_W'(aec_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign rd_rec = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + aec_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + aec_pkg::QUEUE_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + aec_pkg::QUEUE_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - aec_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/aec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module aec_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire aec_pkg::tick_rec_t                head,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [aec_pkg::OUT_TDATA_W-1:0]        m_data,
    output logic                                   m_last
);

    logic [aec_pkg::CUE_CNT_W-1:0]   k_reg;
    logic                            valid_reg;
    logic [aec_pkg::OUT_TDATA_W-1:0] data_reg;
    logic                            last_reg;
    logic                            out_free, load, is_last;
    logic [2:0]                      cue_val;

    // Output register is free when empty or being taken.
    assign out_free = !valid_reg || m_ready;
    assign load     = !q_empty && out_free;
    assign is_last  = (head.cue_count == '0) ||
                      (k_reg == head.cue_count - aec_pkg::CUE_CNT_W'(1));
    assign cue_val  = (head.cue_count == '0) ? aec_pkg::CUE_NONE : head.cues[k_reg];
    assign pop      = load && is_last;

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign m_last  = last_reg;

    // Cue index within the head record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                k_reg <= is_last ? '0 : k_reg + aec_pkg::CUE_CNT_W'(1);
            end
            if (out_free)
            begin
                valid_reg <= !q_empty;
            end
        end
    end

    // Result payload, level fields in the low bits.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {2'b00, cue_val, head.status.tone_hz, head.status.tone_on,
                         head.status.siren, head.status.buzzer, head.status.led,
                         head.status.level};
            last_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

// File: design/alarm_escalation_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Alarm escalation controller.
// Each request on the s_axis channel is one millisecond tick carrying the
// switch levels. The block updates its alarm level, blink, siren and tone
// timers on that tick and returns one to five requests on m_axis: one per
// sound cue in order, or a single request with no cue on a quiet tick. All
// requests of a tick carry the same end-of-tick levels; tlast marks the final.
// The first result of a tick passes through the queue and then the result
// register. Throughput: a tick is taken in every cycle while the four-entry
// queue between the tick logic and the result stage has room; the result
// stage drains one request per cycle while m_axis is ready, so a tick with
// n cues occupies it for max(n, 1) requests. The cfg channel is always
// ready and writes register cfg_index with cfg_data. Reset clears all
// timers, sets level disarmed, empties the queue and loads the register
// defaults. When m_axis stalls, the held result stays stable, the queue
// fills and then s_axis_tready drops.
module alarm_escalation_controller #(
    parameter int TONE_STEP_MS = aec_pkg::TONE_STEP_MS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // armed_switch, gates_open, lockdown_switch, panic_button, reset_button
    input  wire logic [aec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // alarm_level, led_on, buzzer_on, siren_on, tone_on, tone_hz, sound_cue
    output logic [aec_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [aec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [aec_pkg::CFG_W-1:0]          cfg_data
);

    aec_pkg::tick_rec_t wr_rec, rd_rec;
    logic               q_full, q_empty, take, pop;

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Tick classification and controller state.
    aec_front #(
        .TONE_STEP_MS(TONE_STEP_MS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .switches  (s_axis_tdata[4:0]),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec       (wr_rec)
    );

    // Decoupling queue.
    aec_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Result serializer.
    aec_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (rd_rec),
        .pop     (pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: design/aec_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module aec_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic [aec_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic                           m_axis_tlast
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Results of one tick share the same levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata[18:0] == $past(m_axis_tdata[18:0])))
        else $error("levels changed within a tick");

    // Only the last result of a tick may carry no cue.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[21:19] != aec_pkg::CUE_NONE)
        else $error("non-final result without a cue");

    // Disarmed drives nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == aec_pkg::LVL_DISARMED |->
            m_axis_tdata[6:3] == 4'b0000)
        else $error("outputs active while disarmed");

    // Guard only blinks the LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == aec_pkg::LVL_GUARD |->
            m_axis_tdata[6:4] == 3'b000)
        else $error("buzzer, siren or tone active in guard");

endmodule

bind alarm_escalation_controller aec_checker u_aec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: sim/alarm_escalation_controller_test.sv
`timescale 1ns / 1ps

module alarm_escalation_controller_test;

    import aec_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int REPORT_LIMIT   = 10;

    // One result request as it appears on {m_axis_tlast, m_axis_tdata}.
    typedef struct packed {
        logic            last;
        logic [1:0]      pad;
        logic [2:0]      cue;
        logic [HZ_W-1:0] tone_hz;
        logic            tone_on;
        logic            siren;
        logic            buzzer;
        logic            led;
        logic [2:0]      level;
    } tick_result_t;

    // Predicts the results of each tick and checks the block against them.
    class alarm_scoreboard;
        logic [CFG_W-1:0] warn_to_speak, speak_to_siren, siren_to_defend;
        logic [CFG_W-1:0] guard_blink, warn_blink, siren_toggle;
        logic [HZ_W-1:0]  tone_low, tone_high;

        level_t          lvl;
        bit              retrig_latch;
        int unsigned     level_ms, guard_ms, warn_ms, siren_ms, step_ms;
        bit              led, buzzer, siren, tone_on;
        logic [HZ_W-1:0] tone_hz;
        cue_t            tick_cues[$];

        tick_result_t    expected_outputs[$];
        int              failures;

        function new();
            warn_to_speak   = WARN_TO_SPEAK_RST;
            speak_to_siren  = SPEAK_TO_SIREN_RST;
            siren_to_defend = SIREN_TO_DEFEND_RST;
            guard_blink     = GUARD_BLINK_RST;
            warn_blink      = WARN_BLINK_RST;
            siren_toggle    = SIREN_TOGGLE_RST;
            tone_low        = TONE_LOW_RST;
            tone_high       = TONE_HIGH_RST;
            lvl             = LVL_DISARMED;
            retrig_latch    = 1'b0;
            level_ms        = 0;
            guard_ms        = 0;
            warn_ms         = 0;
            siren_ms        = 0;
            step_ms         = 0;
            led             = 1'b0;
            buzzer          = 1'b0;
            siren           = 1'b0;
            tone_on         = 1'b0;
            tone_hz         = TONE_LOW_RST;
            failures        = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_WARN_TO_SPEAK:   warn_to_speak   = value;
                REG_SPEAK_TO_SIREN:  speak_to_siren  = value;
                REG_SIREN_TO_DEFEND: siren_to_defend = value;
                REG_GUARD_BLINK:     guard_blink     = value;
                REG_WARN_BLINK:      warn_blink      = value;
                REG_SIREN_TOGGLE:    siren_toggle    = value;
                REG_TONE_LOW:        tone_low        = value[HZ_W-1:0];
                REG_TONE_HIGH:       tone_high       = value[HZ_W-1:0];
                default: ;
            endcase
        endfunction

        // A tick never reports more than six cues.
        function void add_cue(cue_t c);
            if (tick_cues.size() < MAX_CUES)
                tick_cues.push_back(c);
        endfunction

        function void enter_siren();
            lvl = LVL_SIREN;
            add_cue(CUE_DOUBLE);
            add_cue(CUE_LONG);
        endfunction

        function void enter_disarmed();
            lvl = LVL_DISARMED;
            add_cue(CUE_SHORT);
        endfunction

        function void enter_guard_reset();
            retrig_latch = 1'b1;
            lvl = LVL_GUARD;
            add_cue(CUE_SHORT);
        endfunction

        // The sweep steps up by one and wraps to the start at the top.
        function void sweep_tone();
            if (step_ms >= TONE_STEP_MS_DEF) begin
                tone_hz = (tone_hz >= tone_high) ? tone_low : tone_hz + 1'b1;
                tone_on = 1'b1;
                step_ms = 0;
            end
        endfunction

        function void toggle_siren();
            if (siren_ms >= siren_toggle) begin
                siren   = !siren;
                buzzer  = !buzzer;
                siren_ms = 0;
            end
        endfunction

        function int unsigned bump(int unsigned v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        // Advance the alarm by one tick and queue the results it causes.
        function void note_tick(logic [4:0] sw);
            bit           armed, gates, lockdown, panic, rst;
            level_t       start;
            tick_result_t o;
            int           n;
            armed    = sw[0];
            gates    = sw[1];
            lockdown = sw[2];
            panic    = sw[3];
            rst      = sw[4];
            start    = lvl;
            tick_cues.delete();

            case (lvl)
                LVL_DISARMED: begin
                    if (armed) begin
                        lvl = LVL_GUARD;
                        add_cue(CUE_DOUBLE);
                    end
                end
                LVL_GUARD: begin
                    if (guard_ms >= guard_blink) begin
                        led = !led;
                        guard_ms = 0;
                    end
                    if (armed) begin
                        if (gates) begin
                            if (!retrig_latch) begin
                                if (lockdown) begin
                                    enter_siren();
                                end
                                else begin
                                    lvl = LVL_WARN;
                                    add_cue(CUE_DOUBLE);
                                end
                            end
                        end
                        else begin
                            retrig_latch = 1'b0;
                        end
                    end
                    else begin
                        enter_disarmed();
                    end
                    if (panic)
                        enter_siren();
                end
                LVL_WARN, LVL_SPEAK: begin
                    // Warn beeps briefly, speak sweeps the tone.
                    if (lvl == LVL_WARN) begin
                        if (warn_ms >= warn_blink) begin
                            led    = 1'b0;
                            buzzer = 1'b0;
                            add_cue(CUE_SHORT);
                            warn_ms = 0;
                        end
                    end
                    else begin
                        sweep_tone();
                    end
                    if (armed) begin
                        if (gates) begin
                            if (level_ms >= ((lvl == LVL_WARN) ? warn_to_speak
                                                               : speak_to_siren)) begin
                                if (lvl == LVL_WARN) begin
                                    lvl = LVL_SPEAK;
                                    add_cue(CUE_DOUBLE);
                                end
                                else begin
                                    enter_siren();
                                end
                            end
                        end
                        else begin
                            lvl = LVL_GUARD;
                            add_cue(CUE_SHORT);
                        end
                    end
                    else begin
                        enter_disarmed();
                    end
                    if (panic)
                        enter_siren();
                    if (rst)
                        enter_guard_reset();
                end
                LVL_SIREN: begin
                    sweep_tone();
                    toggle_siren();
                    if (armed) begin
                        if (level_ms >= siren_to_defend) begin
                            lvl = LVL_DEFEND;
                            add_cue(CUE_DOUBLE);
                            add_cue(CUE_LONGER);
                        end
                    end
                    else begin
                        enter_disarmed();
                    end
                    if (rst)
                        enter_guard_reset();
                end
                LVL_DEFEND: begin
                    sweep_tone();
                    toggle_siren();
                    if (!armed)
                        enter_disarmed();
                    if (rst)
                        enter_guard_reset();
                end
                default: ;
            endcase

            // Entering a new level clears every output.
            if (lvl != start) begin
                level_ms = 0;
                led      = 1'b0;
                buzzer   = 1'b0;
                tone_on  = 1'b0;
                tone_hz  = tone_low;
                siren    = 1'b0;
            end

            level_ms = bump(level_ms);
            guard_ms = bump(guard_ms);
            warn_ms  = bump(warn_ms);
            siren_ms = bump(siren_ms);
            step_ms  = bump(step_ms);

            // One result per cue, or a single quiet one.
            n = (tick_cues.size() == 0) ? 1 : tick_cues.size();
            for (int k = 0; k < n; k++) begin
                o.last    = (k == n - 1);
                o.pad     = 2'b00;
                o.cue     = (tick_cues.size() == 0) ? CUE_NONE : tick_cues[k];
                o.tone_hz = tone_hz;
                o.tone_on = tone_on;
                o.siren   = siren;
                o.buzzer  = buzzer;
                o.led     = led;
                o.level   = lvl;
                expected_outputs.push_back(o);
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_output(tick_result_t got);
            tick_result_t want;
            if (expected_outputs.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected result %h with nothing pending", $realtime, got);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.level != want.level || got.led != want.led || got.buzzer != want.buzzer
                || got.siren != want.siren || got.tone_on != want.tone_on
                || got.tone_hz != want.tone_hz || got.cue != want.cue
                || got.last != want.last || got.pad != want.pad) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: mismatch: expected lvl %0d led %b buz %b sir %b tone %b/%0d cue %0d last %b pad %b, got lvl %0d led %b buz %b sir %b tone %b/%0d cue %0d last %b pad %b",
                             $realtime, want.level, want.led, want.buzzer, want.siren,
                             want.tone_on, want.tone_hz, want.cue, want.last, want.pad,
                             got.level, got.led, got.buzzer, got.siren, got.tone_on,
                             got.tone_hz, got.cue, got.last, got.pad);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    alarm_scoreboard sb;
    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_requests = 0;
    int  holds_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    bit  armed_run = 1'b1;
    bit  gates_run = 1'b1;

    alarm_escalation_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (holds_seen != hold_requests) begin
                holds_seen    <= hold_requests;
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(tick_result_t'({m_axis_tlast, m_axis_tdata}));
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one tick and wait until the block takes it.
    task automatic send_tick(input logic [4:0] sw);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 5){1'b0}}, sw};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(sw);
    endtask

    // Stop sending and wait for every pending result.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight registers in index order.
    task automatic load_config(input logic [CFG_W-1:0] w2s, s2s, s2d, gblink, wblink,
                               stoggle, input logic [HZ_W-1:0] lo, hi);
        logic [CFG_W-1:0] plan [8];
        plan[REG_WARN_TO_SPEAK]   = w2s;
        plan[REG_SPEAK_TO_SIREN]  = s2s;
        plan[REG_SIREN_TO_DEFEND] = s2d;
        plan[REG_GUARD_BLINK]     = gblink;
        plan[REG_WARN_BLINK]      = wblink;
        plan[REG_SIREN_TOGGLE]    = stoggle;
        plan[REG_TONE_LOW]        = CFG_W'(lo);
        plan[REG_TONE_HIGH]       = CFG_W'(hi);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= plan[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(cfg_reg_t'(i), plan[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly armed runs with long open-gate stretches, some pure noise.
    function automatic logic [4:0] random_switches();
        if ($urandom_range(99) < 10)
            return 5'($urandom);
        if ($urandom_range(99) < (armed_run ? 3 : 30))
            armed_run = !armed_run;
        if ($urandom_range(99) < 15)
            gates_run = !gates_run;
        return {($urandom_range(99) < 7), ($urandom_range(99) < 6),
                ($urandom_range(99) < 8), gates_run, armed_run};
    endfunction

    task automatic run_random(input int count, input int idle, input int stall);
        sender_idle_pct = idle;
        stall_pct       = stall;
        repeat (count)
            send_tick(random_switches());
    endtask

    // Switch order in the ticks below: reset, panic, lockdown, gates, armed.
    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk through the level changes with the reset timings.
        send_tick(5'b00000);
        send_tick(5'b00001);
        send_tick(5'b00011);
        send_tick(5'b01011);
        send_tick(5'b10011);
        send_tick(5'b00011);
        send_tick(5'b00001);
        send_tick(5'b00111);
        send_tick(5'b00110);
        send_tick(5'b00001);
        send_tick(5'b11111);
        send_tick(5'b00000);
        send_tick(5'b01001);
        send_tick(5'b01001);
        send_tick(5'b10001);
        send_tick(5'b00000);
        wait_for_results();

        // Zero periods: every timer fires, so the alarm climbs one level per tick.
        load_config('0, '0, '0, '0, '0, '0, '0, '0);
        send_tick(5'b00001);
        send_tick(5'b00011);
        send_tick(5'b00011);
        send_tick(5'b00011);
        send_tick(5'b00001);
        send_tick(5'b00001);
        send_tick(5'b10001);
        send_tick(5'b00001);
        send_tick(5'b00011);
        send_tick(5'b11011);
        send_tick(5'b00000);
        wait_for_results();

        // Short stays with a narrow sweep; the receiver holds off at the start.
        load_config(20'd3, 20'd4, 20'd5, 20'd2, 20'd1, 20'd2, 12'd10, 12'd14);
        hold_requests = hold_requests + 1;
        run_random(90, 0, 0);
        wait_for_results();

        // Sweep at the top of the range; the sender pauses halfway.
        load_config(20'd2, 20'd1, 20'd3, 20'd0, 20'd3, 20'd1, 12'd4093, 12'd4095);
        run_random(45, 60, 0);
        wait_for_results();
        run_random(45, 60, 0);
        wait_for_results();

        // Largest periods and the full sweep range.
        load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                    12'd0, 12'hFFF);
        run_random(85, 0, 60);
        wait_for_results();

        // Random short periods and random sweep bounds.
        load_config(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)),
                    CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)),
                    CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)),
                    HZ_W'($urandom_range(4095)), HZ_W'($urandom_range(4095)));
        run_random(80, 26, 26);
        wait_for_results();

        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.expected_outputs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
